// ===== src/gtrs_pkg.sv =====
// ----------------------------------------------------------------------------
// gtrs_pkg
// Shared types and constants for the grid tile rank selector.
// ----------------------------------------------------------------------------
package gtrs_pkg;

	localparam int GRID_W   = 6;
	localparam int COUNT_W  = 7;
	localparam int RANK_W   = 3;
	localparam int COORD_W  = 32;
	localparam int STEP_W   = 31;
	localparam int POINTS_W = 16;
	localparam int EDGE_W   = 49;
	localparam int DIFF_W   = 50;
	localparam int PADDR_W  = 4;

	localparam int BOX_LAT_LO = 49;
	localparam int BOX_LAT_HI = 58;
	localparam int BOX_LON_LO = 230;
	localparam int BOX_LON_HI = 234;

	localparam logic [1:0] REG_GRID_COUNT         = 2'd0;
	localparam logic [1:0] REG_OVERLAP_ENABLE     = 2'd1;
	localparam logic [1:0] REG_OVERLAP_GRID       = 2'd2;
	localparam logic [1:0] REG_OVERLAP_GRID_VALID = 2'd3;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [RANK_W-1:0] RANK_NONE   = 3'd0;
	localparam logic [RANK_W-1:0] RANK_CORNER = 3'd1;
	localparam logic [RANK_W-1:0] RANK_EDGE   = 3'd2;
	localparam logic [RANK_W-1:0] RANK_INNER  = 3'd3;
	localparam logic [RANK_W-1:0] RANK_DEEP   = 3'd4;

	typedef struct packed {
		logic                       command;
		logic [GRID_W-1:0]          grid_index;
		logic signed [COORD_W-1:0]  point_lat;
		logic signed [COORD_W-1:0]  point_lon;
		logic signed [COORD_W-1:0]  origin_lat;
		logic signed [COORD_W-1:0]  origin_lon;
		logic [STEP_W-1:0]          lat_spacing;
		logic [STEP_W-1:0]          lon_spacing;
		logic [POINTS_W-1:0]        lat_points;
		logic [POINTS_W-1:0]        lon_points;
		logic                       grid_present;
	} item_t;

	typedef struct packed {
		logic [GRID_W-1:0] selected_grid;
		logic              grid_found;
		logic [RANK_W-1:0] selected_rank;
		logic              overlap_used;
	} result_t;

	typedef struct packed {
		logic [COUNT_W-1:0] grid_count;
		logic               overlap_enable;
		logic [GRID_W-1:0]  overlap_grid;
		logic               overlap_grid_valid;
	} cfg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] south;
		logic signed [EDGE_W-1:0]  north;
		logic signed [COORD_W-1:0] west;
		logic signed [EDGE_W-1:0]  east;
		logic [STEP_W-1:0]         lat_step;
		logic [STEP_W-1:0]         lon_step;
	} tile_t;

	typedef struct packed {
		logic capture;
		logic ld_mul;
		logic ld_write;
		logic scan_init;
		logic scan_issue;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_query;
		logic load_ok;
		logic scan_empty;
		logic scan_last;
		logic pipe_busy;
	} dp_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LOAD_MUL,
		ST_LOAD_WR,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// ===== src/gtrs_ram.sv =====
// ----------------------------------------------------------------------------
// gtrs_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module gtrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/gtrs_regs.sv =====
// ----------------------------------------------------------------------------
// gtrs_regs
// APB configuration registers.
// ----------------------------------------------------------------------------
module gtrs_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gtrs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output gtrs_pkg::cfg_t               cfg
);

	gtrs_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				gtrs_pkg::REG_GRID_COUNT: begin
					cfg_q.grid_count <= pwdata[gtrs_pkg::COUNT_W-1:0];
				end
				gtrs_pkg::REG_OVERLAP_ENABLE: begin
					cfg_q.overlap_enable <= pwdata[0];
				end
				gtrs_pkg::REG_OVERLAP_GRID: begin
					cfg_q.overlap_grid <= pwdata[gtrs_pkg::GRID_W-1:0];
				end
				gtrs_pkg::REG_OVERLAP_GRID_VALID: begin
					cfg_q.overlap_grid_valid <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			gtrs_pkg::REG_GRID_COUNT: begin
				prdata = {{(32-gtrs_pkg::COUNT_W){1'b0}}, cfg_q.grid_count};
			end
			gtrs_pkg::REG_OVERLAP_ENABLE: begin
				prdata = {31'd0, cfg_q.overlap_enable};
			end
			gtrs_pkg::REG_OVERLAP_GRID: begin
				prdata = {{(32-gtrs_pkg::GRID_W){1'b0}}, cfg_q.overlap_grid};
			end
			gtrs_pkg::REG_OVERLAP_GRID_VALID: begin
				prdata = {31'd0, cfg_q.overlap_grid_valid};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

// ===== src/gtrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// gtrs_ctrl
// Sequencer for load and query words.
// ----------------------------------------------------------------------------
module gtrs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  gtrs_pkg::dp_status_t status,
	output gtrs_pkg::ctl_cmd_t   cmd,
	output logic                 busy
);

	gtrs_pkg::state_t state_q;
	gtrs_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gtrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		busy       = 1'b1;
		unique case (state_q)
			gtrs_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_next  = gtrs_pkg::ST_DECODE;
				end
			end
			gtrs_pkg::ST_DECODE: begin
				if (status.is_query) begin
					cmd.scan_init = 1'b1;
					state_next    = status.scan_empty ? gtrs_pkg::ST_DONE : gtrs_pkg::ST_SCAN;
				end else begin
					state_next = status.load_ok ? gtrs_pkg::ST_LOAD_MUL : gtrs_pkg::ST_IDLE;
				end
			end
			gtrs_pkg::ST_LOAD_MUL: begin
				cmd.ld_mul = 1'b1;
				state_next = gtrs_pkg::ST_LOAD_WR;
			end
			gtrs_pkg::ST_LOAD_WR: begin
				cmd.ld_write = 1'b1;
				state_next   = gtrs_pkg::ST_IDLE;
			end
			gtrs_pkg::ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (status.scan_last) begin
					state_next = gtrs_pkg::ST_DRAIN;
				end
			end
			gtrs_pkg::ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_next = gtrs_pkg::ST_DONE;
				end
			end
			gtrs_pkg::ST_DONE: begin
				cmd.finish = 1'b1;
				state_next = gtrs_pkg::ST_IDLE;
			end
			default: begin
				state_next = gtrs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/gtrs_dp.sv =====
// ----------------------------------------------------------------------------
// gtrs_dp
// Tile table, edge precompute, rank pipeline and best-tile tracking.
// ----------------------------------------------------------------------------
module gtrs_dp #(
	parameter int MAX_GRIDS     = 64,
	parameter int FRACTION_BITS = 22
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gtrs_pkg::item_t      item,
	input  gtrs_pkg::cfg_t       cfg,
	input  gtrs_pkg::ctl_cmd_t   cmd,
	output gtrs_pkg::dp_status_t status,
	output gtrs_pkg::result_t    result,
	output logic                 done
);

	localparam int IdxW = (MAX_GRIDS > 1) ? $clog2(MAX_GRIDS) : 1;
	localparam int CmpW = (FRACTION_BITS + 9 > 32) ? FRACTION_BITS + 9 : 32;
	localparam int CW   = gtrs_pkg::COUNT_W;
	localparam int DW   = gtrs_pkg::DIFF_W;

	localparam logic signed [CmpW-1:0] LatLo = signed'(CmpW'(gtrs_pkg::BOX_LAT_LO) << FRACTION_BITS);
	localparam logic signed [CmpW-1:0] LatHi = signed'(CmpW'(gtrs_pkg::BOX_LAT_HI) << FRACTION_BITS);
	localparam logic signed [CmpW-1:0] LonLo = signed'(CmpW'(gtrs_pkg::BOX_LON_LO) << FRACTION_BITS);
	localparam logic signed [CmpW-1:0] LonHi = signed'(CmpW'(gtrs_pkg::BOX_LON_HI) << FRACTION_BITS);
	localparam logic [CW-1:0]          MaxCount = CW'(MAX_GRIDS);

	gtrs_pkg::item_t   item_q;
	gtrs_pkg::result_t result_q;
	logic              done_q;

	// load edge precompute
	logic signed [16:0]                    nl_m1;
	logic signed [16:0]                    nn_m1;
	logic signed [gtrs_pkg::EDGE_W-1:0]    lat_prod_c;
	logic signed [gtrs_pkg::EDGE_W-1:0]    lon_prod_c;
	logic signed [gtrs_pkg::EDGE_W-1:0]    lat_prod_q;
	logic signed [gtrs_pkg::EDGE_W-1:0]    lon_prod_q;
	gtrs_pkg::tile_t                       tile_wr;
	logic [MAX_GRIDS-1:0]                  tile_valid_q;
	logic [IdxW-1:0]                       load_idx;

	// scan control
	logic [CW-1:0]   count;
	logic            in_box;
	logic            ovr_hit;
	logic [IdxW-1:0] addr_q;
	logic [IdxW-1:0] end_q;
	logic            force_q;

	// rank pipeline
	gtrs_pkg::tile_t      tile_s1;
	logic                 v_s1;
	logic                 tv_s1;
	logic [IdxW-1:0]      idx_s1;
	logic signed [DW-1:0] lat_x;
	logic signed [DW-1:0] lon_x;
	logic signed [DW-1:0] ds_s2;
	logic signed [DW-1:0] dn_s2;
	logic signed [DW-1:0] dw_s2;
	logic signed [DW-1:0] de_s2;
	logic [gtrs_pkg::STEP_W-1:0] sl_s2;
	logic [gtrs_pkg::STEP_W-1:0] so_s2;
	logic                 v_s2;
	logic                 tv_s2;
	logic [IdxW-1:0]      idx_s2;
	logic [gtrs_pkg::RANK_W-1:0] rank_c;
	logic [gtrs_pkg::RANK_W-1:0] rank_s3;
	logic                 v_s3;
	logic [IdxW-1:0]      idx_s3;
	logic [gtrs_pkg::RANK_W-1:0] best_rank_q;
	logic [IdxW-1:0]      best_idx_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
	end

	// ---- load path ----
	assign nl_m1      = $signed({1'b0, item_q.lat_points}) - 17'sd1;
	assign nn_m1      = $signed({1'b0, item_q.lon_points}) - 17'sd1;
	assign lat_prod_c = $signed({1'b0, item_q.lat_spacing}) * nl_m1;
	assign lon_prod_c = $signed({1'b0, item_q.lon_spacing}) * nn_m1;

	always_ff @(posedge clk) begin
		if (cmd.ld_mul) begin
			lat_prod_q <= lat_prod_c;
			lon_prod_q <= lon_prod_c;
		end
	end

	always_comb begin
		tile_wr.south    = item_q.origin_lat;
		tile_wr.west     = item_q.origin_lon;
		tile_wr.lat_step = item_q.lat_spacing;
		tile_wr.lon_step = item_q.lon_spacing;
		tile_wr.north    = {{(gtrs_pkg::EDGE_W-32){item_q.origin_lat[31]}}, item_q.origin_lat}
			+ lat_prod_q;
		tile_wr.east     = {{(gtrs_pkg::EDGE_W-32){item_q.origin_lon[31]}}, item_q.origin_lon}
			+ lon_prod_q;
	end

	assign load_idx = IdxW'(item_q.grid_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_valid_q <= '0;
		end else if (cmd.ld_write) begin
			tile_valid_q[load_idx] <= item_q.grid_present;
		end
	end

	gtrs_ram #(
		.WIDTH ($bits(gtrs_pkg::tile_t)),
		.DEPTH (MAX_GRIDS)
	) u_tiles (
		.clk   (clk),
		.we    (cmd.ld_write),
		.waddr (load_idx),
		.wdata (tile_wr),
		.raddr (addr_q),
		.rdata (tile_s1)
	);

	// ---- query setup ----
	assign count  = (cfg.grid_count > MaxCount) ? MaxCount : cfg.grid_count;
	assign in_box = ({{(CmpW-32){item_q.point_lat[31]}}, item_q.point_lat} >= LatLo)
		&& ({{(CmpW-32){item_q.point_lat[31]}}, item_q.point_lat} <= LatHi)
		&& ({{(CmpW-32){item_q.point_lon[31]}}, item_q.point_lon} >= LonLo)
		&& ({{(CmpW-32){item_q.point_lon[31]}}, item_q.point_lon} <= LonHi);
	assign ovr_hit = cfg.overlap_enable && cfg.overlap_grid_valid
		&& ({1'b0, cfg.overlap_grid} < count) && in_box;

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			addr_q  <= ovr_hit ? IdxW'(cfg.overlap_grid) : '0;
			end_q   <= ovr_hit ? IdxW'(cfg.overlap_grid) : IdxW'(count - 7'd1);
			force_q <= ovr_hit;
		end else if (cmd.scan_issue) begin
			addr_q <= addr_q + 1'b1;
		end
	end

	// ---- rank pipeline ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		tv_s1  <= tile_valid_q[addr_q];
		idx_s1 <= addr_q;
	end

	assign lat_x = {{(DW-32){item_q.point_lat[31]}}, item_q.point_lat};
	assign lon_x = {{(DW-32){item_q.point_lon[31]}}, item_q.point_lon};

	always_ff @(posedge clk) begin
		ds_s2  <= lat_x - {{(DW-32){tile_s1.south[31]}}, tile_s1.south};
		dn_s2  <= {{(DW-gtrs_pkg::EDGE_W){tile_s1.north[gtrs_pkg::EDGE_W-1]}}, tile_s1.north}
			- lat_x;
		dw_s2  <= lon_x - {{(DW-32){tile_s1.west[31]}}, tile_s1.west};
		de_s2  <= {{(DW-gtrs_pkg::EDGE_W){tile_s1.east[gtrs_pkg::EDGE_W-1]}}, tile_s1.east}
			- lon_x;
		sl_s2  <= tile_s1.lat_step;
		so_s2  <= tile_s1.lon_step;
		tv_s2  <= tv_s1;
		idx_s2 <= idx_s1;
	end

	always_comb begin
		logic signed [DW-1:0] sl1;
		logic signed [DW-1:0] sl2;
		logic signed [DW-1:0] so1;
		logic signed [DW-1:0] so2;
		logic ne, se, we, ee;
		sl1 = {{(DW-gtrs_pkg::STEP_W){1'b0}}, sl_s2};
		sl2 = {{(DW-gtrs_pkg::STEP_W-1){1'b0}}, sl_s2, 1'b0};
		so1 = {{(DW-gtrs_pkg::STEP_W){1'b0}}, so_s2};
		so2 = {{(DW-gtrs_pkg::STEP_W-1){1'b0}}, so_s2, 1'b0};
		ne  = dn_s2 <= sl1;
		se  = ds_s2 <= sl1;
		ee  = de_s2 <= so1;
		we  = dw_s2 <= so1;
		rank_c = gtrs_pkg::RANK_NONE;
		if (!tv_s2 || ds_s2[DW-1] || dn_s2[DW-1] || dw_s2[DW-1] || de_s2[DW-1]) begin
			rank_c = gtrs_pkg::RANK_NONE;
		end else if (ds_s2 > sl2 && dn_s2 > sl2 && dw_s2 > so2 && de_s2 > so2) begin
			rank_c = gtrs_pkg::RANK_DEEP;
		end else if (!ne && !se && !ee && !we) begin
			rank_c = gtrs_pkg::RANK_INNER;
		end else if ((ne || se) && (we || ee)) begin
			rank_c = gtrs_pkg::RANK_CORNER;
		end else begin
			rank_c = gtrs_pkg::RANK_EDGE;
		end
	end

	always_ff @(posedge clk) begin
		rank_s3 <= rank_c;
		idx_s3  <= idx_s2;
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			best_rank_q <= gtrs_pkg::RANK_NONE;
			best_idx_q  <= ovr_hit ? IdxW'(cfg.overlap_grid) : '0;
		end else if (v_s3 && (force_q || rank_s3 > best_rank_q)) begin
			best_rank_q <= rank_s3;
			best_idx_q  <= idx_s3;
		end
	end

	// ---- result ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.selected_grid <= gtrs_pkg::GRID_W'(best_idx_q);
			result_q.grid_found    <= force_q || (best_rank_q != gtrs_pkg::RANK_NONE);
			result_q.selected_rank <= best_rank_q;
			result_q.overlap_used  <= force_q;
		end
	end

	assign result = result_q;
	assign done   = done_q;

	assign status.is_query   = (item_q.command == gtrs_pkg::CMD_QUERY);
	assign status.load_ok    = ({1'b0, item_q.grid_index} < MaxCount);
	assign status.scan_empty = !ovr_hit && (count == '0);
	assign status.scan_last  = (addr_q == end_q);
	assign status.pipe_busy  = v_s1 | v_s2 | v_s3;

endmodule

// ===== src/grid_tile_rank_select.sv =====
// ----------------------------------------------------------------------------
// grid_tile_rank_select
// Query: scans N = min(grid_count, MAX_GRIDS) tiles, or the overlap tile alone
// under overlap override, and none when N is 0; busy drops in the done cycle.
// One tile a cycle through the tile RAM read port, then a three stage rank pipe.
// Load: busy throughout, no result. done is a one cycle strobe.
// Reset clears FSM, config, done, valid and tile present bits; not the tile RAM.
// ----------------------------------------------------------------------------
module grid_tile_rank_select #(
	parameter int MAX_GRIDS     = 64,
	parameter int FRACTION_BITS = 22
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  gtrs_pkg::item_t              item,
	output logic                         done,
	output gtrs_pkg::result_t            result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gtrs_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	gtrs_pkg::cfg_t       cfg;
	gtrs_pkg::ctl_cmd_t   cmd;
	gtrs_pkg::dp_status_t status;

	gtrs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gtrs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	gtrs_dp #(
		.MAX_GRIDS     (MAX_GRIDS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.cmd    (cmd),
		.status (status),
		.result (result),
		.done   (done)
	);

endmodule
